/* hw/rtl/four_level_page_table_walker_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the four-level page table walker
// Concurrent property wrappers used by the checker file fpw_checker.sv.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_ASSERT_SVH

// same-cycle implication
`define FPW_ASSERT_IMPLY(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define FPW_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* hw/rtl/fpw_pkg.sv */
// ----------------------------------------------------------------------------
// fpw_pkg
// Shared types and constants of the four-level page table walker.
// ----------------------------------------------------------------------------
package fpw_pkg;

    localparam int TABLE_FRAMES  = 16;
    localparam int IDX_W         = 9;
    localparam int FRAME_W       = $clog2(TABLE_FRAMES);
    localparam int STORE_IDX_W   = FRAME_W + IDX_W;
    localparam int STORE_DEPTH   = TABLE_FRAMES * (2 ** IDX_W);

    localparam int CMD_W         = 2;
    localparam int VA_W          = 48;
    localparam int WORD_INDEX_W  = 13;
    localparam int WORD_W        = 64;
    localparam int PA_W          = 52;
    localparam int S_TDATA_W     = 128;
    localparam int M_TDATA_W     = 56;

    localparam int BIT_PRESENT   = 0;
    localparam int BIT_USER      = 2;
    localparam int BIT_HUGE      = 7;
    localparam int PAGE_SHIFT    = 12;
    localparam int HUGE_SHIFT    = 21;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE     = 2'd0,
        CMD_TRANSLATE = 2'd1,
        CMD_UNMAP     = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        LVL_PT   = 2'd0,
        LVL_PD   = 2'd1,
        LVL_PDPT = 2'd2,
        LVL_PML4 = 2'd3
    } level_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic            unmap_done;
        logic [PA_W-1:0] phys_addr;
        logic            user_allowed;
        logic            mapped;
    } result_t;

    function automatic logic [IDX_W-1:0] idx_of(input logic [VA_W-1:0] va,
                                                 input level_t lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            LVL_PML4: idx = va[47:39];
            LVL_PDPT: idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            LVL_PT:   idx = va[20:12];
            default:  idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

/* hw/rtl/fpw_table_ram.sv */
// ----------------------------------------------------------------------------
// fpw_table_ram
// Single-port synchronous RAM; read data is registered, valid the cycle after the address.
// ----------------------------------------------------------------------------
module fpw_table_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/four_level_page_table_walker_unit.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_walker_unit
// Walks a four-level page table held in an internal single-port table RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_tvalid/s_tready carry a command in s_tuser and
//   virt_addr, word_index, word_data in s_tdata. Each beat yields exactly
//   one result beat on m_tvalid/m_tready (mapped, user_allowed, phys_addr,
//   unmap_done). cfg_we/cfg_wdata load root_frame; write it only while idle.
//   A table write, an unknown command or an unaligned unmap has its result
//   registered at acceptance. A walk issues one table read per level and
//   decides on each entry the cycle after its read; an unmap writes the
//   cleared entry back when it decides on the last-level entry. One beat
//   is in flight at a time: no new beat is taken until the last result
//   reaches the output register, and a full walk makes four dependent
//   reads through the RAM port. Reset clears control state and root_frame;
//   the table RAM holds garbage until written. When m_tready is low the
//   result stays in the output register; a following result waits in a
//   holding register, and s_tready stays low until it moves to the output.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [fpw_pkg::FRAME_W-1:0]   cfg_wdata,   // root_frame
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // virt_addr[47:0], word_index[60:48], word_data[124:61], zero pad
    input  logic [fpw_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [fpw_pkg::CMD_W-1:0]     s_tuser,     // cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // mapped[0], user_allowed[1], phys_addr[53:2], unmap_done[54], zero pad
    output logic [fpw_pkg::M_TDATA_W-1:0] m_tdata
);

    import fpw_pkg::*;

    localparam int WIDX_LSB = VA_W;
    localparam int WDAT_LSB = VA_W + WORD_INDEX_W;
    localparam int PAD_W    = M_TDATA_W - $bits(result_t);

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    level_t                 level_reg, level_next;
    logic [VA_W-1:0]        va_reg, va_next;
    logic                   user_reg, user_next;
    logic [STORE_IDX_W-1:0] slot_reg, slot_next;
    result_t                hold_reg, hold_next;
    result_t                out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0]     root_frame_reg;

    logic                   ram_we;
    logic [STORE_IDX_W-1:0] ram_addr;
    logic [WORD_W-1:0]      ram_wdata;
    logic [WORD_W-1:0]      ram_rdata;

    cmd_t                   in_cmd;
    logic [VA_W-1:0]        in_va;
    logic [WORD_INDEX_W-1:0] in_widx;
    logic [WORD_W-1:0]      in_wdata;
    logic [STORE_IDX_W-1:0] root_slot;
    logic [STORE_IDX_W-1:0] next_slot;
    level_t                 lower_level;
    logic                   user_acc;
    logic                   out_free;
    logic                   fin;
    result_t                fin_res;

    fpw_table_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (WORD_W)
    ) u_table_ram (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_cmd    = cmd_t'(s_tuser);
    assign in_va     = s_tdata[VA_W-1:0];
    assign in_widx   = s_tdata[WIDX_LSB +: WORD_INDEX_W];
    assign in_wdata  = s_tdata[WDAT_LSB +: WORD_W];
    assign root_slot = {root_frame_reg, idx_of(in_va, LVL_PML4)};

    always_comb begin
        unique case (level_reg)
            LVL_PML4: lower_level = LVL_PDPT;
            LVL_PDPT: lower_level = LVL_PD;
            LVL_PD:   lower_level = LVL_PT;
            LVL_PT:   lower_level = LVL_PT;
            default:  lower_level = LVL_PT;
        endcase
    end

    assign next_slot = {ram_rdata[PAGE_SHIFT +: FRAME_W], idx_of(va_reg, lower_level)};
    assign user_acc  = user_reg & ram_rdata[BIT_USER];
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{PAD_W{1'b0}}, out_reg};

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        level_next     = level_reg;
        va_next        = va_reg;
        user_next      = user_reg;
        slot_next      = slot_reg;
        hold_next      = hold_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_addr       = slot_reg;
        ram_wdata      = '0;
        fin            = 1'b0;
        fin_res        = '0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = in_cmd;
                    va_next    = in_va;
                    user_next  = 1'b1;
                    level_next = LVL_PML4;
                    unique case (in_cmd)
                        CMD_WRITE: begin
                            ram_we    = 1'b1;
                            ram_addr  = in_widx[STORE_IDX_W-1:0];
                            ram_wdata = in_wdata;
                            fin       = 1'b1;
                        end
                        CMD_TRANSLATE: begin
                            ram_addr   = root_slot;
                            slot_next  = root_slot;
                            state_next = ST_WALK;
                        end
                        CMD_UNMAP: begin
                            if (in_va[PAGE_SHIFT-1:0] == '0) begin
                                ram_addr   = root_slot;
                                slot_next  = root_slot;
                                state_next = ST_WALK;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                priority if (!ram_rdata[BIT_PRESENT]) begin
                    fin = 1'b1;
                end else if (level_reg == LVL_PD && cmd_reg == CMD_TRANSLATE
                             && ram_rdata[BIT_HUGE]) begin
                    fin                  = 1'b1;
                    fin_res.mapped       = 1'b1;
                    fin_res.user_allowed = user_acc;
                    fin_res.phys_addr    = {ram_rdata[PA_W-1:HUGE_SHIFT],
                                            va_reg[HUGE_SHIFT-1:0]};
                end else if (level_reg == LVL_PT) begin
                    fin = 1'b1;
                    if (cmd_reg == CMD_UNMAP) begin
                        ram_we             = 1'b1;
                        ram_addr           = slot_reg;
                        fin_res.unmap_done = 1'b1;
                    end else begin
                        fin_res.mapped       = 1'b1;
                        fin_res.user_allowed = user_acc;
                        fin_res.phys_addr    = {ram_rdata[PA_W-1:PAGE_SHIFT],
                                                va_reg[PAGE_SHIFT-1:0]};
                    end
                end else begin
                    ram_addr   = next_slot;
                    slot_next  = next_slot;
                    level_next = lower_level;
                    user_next  = user_acc;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    out_next       = hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                out_next       = fin_res;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end else begin
                hold_next  = fin_res;
                state_next = ST_HOLD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            root_frame_reg <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                root_frame_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        level_reg <= level_next;
        va_reg    <= va_next;
        user_reg  <= user_next;
        slot_reg  <= slot_next;
        hold_reg  <= hold_next;
        out_reg   <= out_next;
    end

endmodule

/* hw/rtl/fpw_checker.sv */
// ----------------------------------------------------------------------------
// fpw_checker
// Port-level properties of the page table walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "four_level_page_table_walker_unit_assert.svh"

module fpw_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fpw_pkg::M_TDATA_W-1:0] m_tdata
);

    import fpw_pkg::*;

    `FPW_ASSERT_NEXT(a_reset_clears_out, aclk, 1'b0, !aresetn, !m_tvalid)
    `FPW_ASSERT_NEXT(a_out_held, aclk, !aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))
    `FPW_ASSERT_IMPLY(a_map_xor_unmap, aclk, !aresetn, m_tvalid,
        !(m_tdata[0] && m_tdata[PA_W+2]))
    `FPW_ASSERT_IMPLY(a_unmapped_zero, aclk, !aresetn, m_tvalid && !m_tdata[0],
        m_tdata[PA_W+1:1] == '0)

endmodule

bind four_level_page_table_walker_unit fpw_checker u_fpw_checker (.*);

/* tb/fpw_walk_checker.sv */
// ----------------------------------------------------------------------------
// fpw_walk_checker
// Watches both streams of the page table walker, keeps its own copy of the
// table store and root frame, predicts each result beat and compares it.
// ----------------------------------------------------------------------------
module fpw_walk_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [fpw_pkg::FRAME_W-1:0]   cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [fpw_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [fpw_pkg::CMD_W-1:0]     s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [fpw_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import fpw_pkg::*;

    logic [WORD_W-1:0]  table_mem [STORE_DEPTH];
    logic [FRAME_W-1:0] root_frame;
    result_t            pending_walk_results [$];
    int                 mismatches  = 0;
    int                 outstanding = 0;
    int                 results_seen = 0;

    assign fail_count = mismatches;
    assign pending    = outstanding;

    function automatic int unsigned entry_slot(input logic [39:0] frame,
                                               input logic [IDX_W-1:0] idx);
        return int'(frame % TABLE_FRAMES) * (2 ** IDX_W) + int'(idx);
    endfunction

    function automatic result_t walk_table(input cmd_t                    cmd,
                                           input logic [VA_W-1:0]         va,
                                           input logic [WORD_INDEX_W-1:0] widx,
                                           input logic [WORD_W-1:0]       wdata);
        result_t           r;
        logic [WORD_W-1:0] e4, e3, e2, e1;
        int unsigned       s1;
        r = '0;
        if (cmd == CMD_WRITE) begin
            table_mem[int'(widx) % STORE_DEPTH] = wdata;
        end else if (cmd == CMD_TRANSLATE || (cmd == CMD_UNMAP && va[11:0] == 12'h0)) begin
            e4 = table_mem[entry_slot({36'h0, root_frame}, va[47:39])];
            if (e4[BIT_PRESENT]) begin
                e3 = table_mem[entry_slot(e4[51:12], va[38:30])];
                if (e3[BIT_PRESENT]) begin
                    e2 = table_mem[entry_slot(e3[51:12], va[29:21])];
                    if (e2[BIT_PRESENT]) begin
                        s1 = entry_slot(e2[51:12], va[20:12]);
                        if (cmd == CMD_UNMAP) begin
                            if (table_mem[s1][BIT_PRESENT]) begin
                                table_mem[s1] = '0;
                                r.unmap_done = 1'b1;
                            end
                        end else if (e2[BIT_HUGE]) begin
                            r.mapped       = 1'b1;
                            r.user_allowed = e4[BIT_USER] & e3[BIT_USER] & e2[BIT_USER];
                            r.phys_addr    = {e2[51:21], va[20:0]};
                        end else begin
                            e1 = table_mem[s1];
                            if (e1[BIT_PRESENT]) begin
                                r.mapped       = 1'b1;
                                r.user_allowed = e4[BIT_USER] & e3[BIT_USER]
                                                 & e2[BIT_USER] & e1[BIT_USER];
                                r.phys_addr    = {e1[51:12], va[11:0]};
                            end
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t seen;
        result_t want;
        if (!aresetn) begin
            root_frame = '0;
            pending_walk_results.delete();
        end else begin
            if (cfg_we)
                root_frame = cfg_wdata;
            if (s_tvalid && s_tready)
                pending_walk_results.push_back(walk_table(cmd_t'(s_tuser), s_tdata[47:0],
                                                          s_tdata[60:48], s_tdata[124:61]));
            if (m_tvalid && m_tready) begin
                seen = result_t'(m_tdata[$bits(result_t)-1:0]);
                results_seen++;
                if (pending_walk_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: no beat outstanding, got tdata %h",
                                 results_seen, m_tdata);
                end else begin
                    want = pending_walk_results.pop_front();
                    if (seen.mapped !== want.mapped || seen.user_allowed !== want.user_allowed
                        || seen.phys_addr !== want.phys_addr
                        || seen.unmap_done !== want.unmap_done) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display(
                                "result %0d exp/got: map %b/%b usr %b/%b pa %h/%h unmap %b/%b",
                                results_seen, want.mapped, seen.mapped,
                                want.user_allowed, seen.user_allowed,
                                want.phys_addr, seen.phys_addr,
                                want.unmap_done, seen.unmap_done);
                    end
                end
            end
        end
        outstanding = pending_walk_results.size();
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives table writes, translations, unmaps and idle commands into the page
// table walker under several root frames, with bursty input and a stalling
// result side, and reports the verdict from the walk checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fpw_pkg::*;

    localparam int CYCLE_LIMIT = 250000;
    localparam int PHASE_ITEMS = 145;

    typedef enum int {DRAIN_FREE, DRAIN_HALF, DRAIN_SLOW} drain_mode_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [FRAME_W-1:0]      cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata   = '0;
    logic [CMD_W-1:0]        s_tuser   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    int                      fail_count;
    int                      pending;

    logic [WORD_W-1:0]       planned_words [STORE_DEPTH];
    bit                      word_written  [STORE_DEPTH];
    logic [FRAME_W-1:0]      active_root = '0;
    logic [VA_W-1:0]         known_vas [$];
    int unsigned             touched_slots [$];
    int                      present_pct = 85;
    int                      huge_pct    = 25;
    int                      burst_left  = 0;
    int                      items_sent  = 0;
    int                      cycle_count = 0;
    drain_mode_t             drain_mode  = DRAIN_FREE;
    int                      drain_left  = 0;

    always #6 aclk = ~aclk;

    four_level_page_table_walker_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    fpw_walk_checker walk_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (drain_left == 0) begin
            drain_mode = drain_mode_t'($urandom_range(0, 2));
            drain_left = $urandom_range(16, 96);
        end else begin
            drain_left--;
        end
        case (drain_mode)
            DRAIN_FREE: m_tready <= 1'b1;
            DRAIN_HALF: m_tready <= 1'($urandom_range(0, 1));
            default:    m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [VA_W-1:0] rand_va();
        return VA_W'({$urandom, $urandom});
    endfunction

    function automatic logic [WORD_W-1:0] table_entry(input level_t lvl);
        logic [WORD_W-1:0] e;
        e = {$urandom, $urandom};
        e[BIT_PRESENT] = ($urandom_range(0, 99) < present_pct);
        e[BIT_USER]    = ($urandom_range(0, 99) < 75);
        if (lvl == LVL_PD)
            e[BIT_HUGE] = ($urandom_range(0, 99) < huge_pct);
        return e;
    endfunction

    // first store word on the walk of va that has never been written
    function automatic bit first_unwritten(input logic [VA_W-1:0] va,
                                           output int unsigned slot, output level_t lvl);
        logic [FRAME_W-1:0] frame;
        int                 l;
        frame = active_root;
        for (l = 3; l >= 0; l--) begin
            slot = int'(frame) * (2 ** IDX_W) + int'(va[PAGE_SHIFT + IDX_W * l +: IDX_W]);
            lvl  = level_t'(l);
            if (!word_written[slot])
                return 1'b1;
            if (!planned_words[slot][BIT_PRESENT])
                return 1'b0;
            frame = planned_words[slot][PAGE_SHIFT +: FRAME_W];
        end
        return 1'b0;
    endfunction

    task automatic send_beat(input cmd_t cmd, input logic [VA_W-1:0] va,
                             input logic [WORD_INDEX_W-1:0] widx,
                             input logic [WORD_W-1:0] wdata);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, wdata, widx, va};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        burst_left--;
        if (burst_left == 0)
            s_tvalid <= 1'b0;
    endtask

    task automatic write_word(input int unsigned idx, input logic [WORD_W-1:0] data);
        send_beat(CMD_WRITE, rand_va(), WORD_INDEX_W'(idx), data);
        planned_words[idx] = data;
        if (!word_written[idx])
            touched_slots.push_back(idx);
        word_written[idx] = 1'b1;
    endtask

    // fill every unwritten word on the path, then walk
    task automatic walk(input cmd_t cmd, input logic [VA_W-1:0] va);
        int unsigned slot;
        level_t      lvl;
        while (first_unwritten(va, slot, lvl))
            write_word(slot, table_entry(lvl));
        send_beat(cmd, va, WORD_INDEX_W'($urandom), {$urandom, $urandom});
    endtask

    task automatic quiesce();
        if (burst_left != 0) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_root(input logic [FRAME_W-1:0] frame);
        quiesce();
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= frame;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        active_root = frame;
    endtask

    task automatic random_item();
        int              r;
        logic [VA_W-1:0] pick;
        logic [VA_W-1:0] va;
        r    = $urandom_range(0, 99);
        pick = known_vas[$urandom_range(0, known_vas.size() - 1)];
        if (r < 30) begin
            va = {pick[47:12], 12'($urandom)};
            if ($urandom_range(0, 3) == 0)
                va[20:0] = 21'($urandom);
            walk(CMD_TRANSLATE, va);
        end else if (r < 45) begin
            va = rand_va();
            known_vas.push_back(va);
            if (known_vas.size() > 24)
                void'(known_vas.pop_front());
            walk(CMD_TRANSLATE, va);
        end else if (r < 62) begin
            walk(CMD_UNMAP, {pick[47:12], 12'h000});
        end else if (r < 67) begin
            walk(CMD_UNMAP, {pick[47:12], 12'($urandom_range(1, 4095))});
        end else if (r < 82) begin
            write_word(touched_slots[$urandom_range(0, touched_slots.size() - 1)],
                       table_entry(level_t'($urandom_range(0, 3))));
        end else if (r < 92) begin
            write_word($urandom_range(0, STORE_DEPTH - 1), {$urandom, $urandom});
        end else if (r < 96) begin
            send_beat(CMD_NONE, rand_va(), WORD_INDEX_W'($urandom), {$urandom, $urandom});
        end else begin
            walk(CMD_TRANSLATE, pick);
        end
    endtask

    initial begin
        logic [FRAME_W-1:0] roots [4];
        int                 phase;
        int                 directed_end;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        set_root('0);
        present_pct = 100;
        huge_pct    = 0;
        write_word(0, '0);
        write_word(STORE_DEPTH - 1, '1);
        walk(CMD_TRANSLATE, '0);
        walk(CMD_TRANSLATE, 48'hFFFF_FFFF_FFFF);
        walk(CMD_UNMAP, 48'hFFFF_FFFF_FFFF);
        walk(CMD_UNMAP, 48'hFFFF_FFFF_F000);
        walk(CMD_TRANSLATE, 48'hFFFF_FFFF_F000);
        walk(CMD_UNMAP, 48'hFFFF_FFFF_F000);
        huge_pct = 100;
        walk(CMD_TRANSLATE, 48'h0080_4020_1ABC);
        walk(CMD_TRANSLATE, 48'h0080_403F_E543);
        walk(CMD_UNMAP, 48'h0080_4020_1000);
        present_pct = 0;
        walk(CMD_TRANSLATE, 48'h5555_5555_5555);
        send_beat(CMD_NONE, '1, '1, '1);
        present_pct = 85;
        huge_pct    = 25;
        known_vas.push_back(48'hFFFF_FFFF_F000);
        known_vas.push_back(48'h0080_4020_1ABC);
        known_vas.push_back(48'h5555_5555_5555);
        directed_end = items_sent;

        roots[0] = '1;
        roots[1] = FRAME_W'($urandom_range(1, TABLE_FRAMES - 2));
        roots[2] = '0;
        roots[3] = FRAME_W'($urandom);
        for (phase = 0; phase < 4; phase++) begin
            set_root(roots[phase]);
            while (items_sent < directed_end + (phase + 1) * PHASE_ITEMS)
                random_item();
        end

        quiesce();
        wait_idle();
        repeat (16) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
